// File: rtl/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on a rising edge and
// disabled while the synchronous active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/gwwb_pkg.sv
// -----------------------------------------------------------------------------
// Gray-world white balance package
// Shared constants, op codes and the controller-to-datapath command struct.
// -----------------------------------------------------------------------------
package gwwb_pkg;

  localparam int LOG_MAX_PIXELS_DEF = 22;
  localparam int SAMPLE_BITS_DEF    = 16;

  // port field widths
  localparam int FIELD_W = 16;
  localparam int OP_W    = 2;

  // gains are unsigned 8.16
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  // divider iteration counter
  localparam int CNT_W = $clog2(GAIN_W);

  typedef enum logic [OP_W-1:0] {
    OP_STAT   = 2'd0,
    OP_FINISH = 2'd1,
    OP_APPLY  = 2'd2
  } op_t;

  typedef struct packed {
    logic acc;    // add pixel to sums
    logic apply;  // scale pixel into output register
    logic load;   // start a gain division
    logic step;   // one quotient bit
    logic store;  // write gain and flag
    logic chan;   // 0 red, 1 blue
    logic clear;  // zero the sums
  } dp_cmd_t;

endpackage

// File: rtl/gwwb_ctrl.sv
// -----------------------------------------------------------------------------
// Gray-world white balance controller
// Handshakes, output valid and the sequencer for the two gain divisions.
// -----------------------------------------------------------------------------
module gwwb_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  input  logic [gwwb_pkg::OP_W-1:0] in_op,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output gwwb_pkg::dp_cmd_t       cmd
);
  import gwwb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_ITER,
    S_STORE
  } state_t;

  state_t           state_r, state_nxt;
  logic             chan_r, chan_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd       = '0;
    cmd.acc   = in_fire && (in_op == OP_STAT);
    cmd.apply = in_fire && (in_op == OP_APPLY);
    cmd.load  = (state_r == S_LOAD);
    cmd.step  = (state_r == S_ITER);
    cmd.store = (state_r == S_STORE);
    cmd.chan  = chan_r;
    cmd.clear = (state_r == S_STORE) && chan_r;
  end

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_op == OP_FINISH)) begin
          state_nxt = S_LOAD;
          chan_nxt  = 1'b0;
        end
      end
      S_LOAD: begin
        state_nxt = S_ITER;
        cnt_nxt   = CNT_W'(GAIN_W - 1);
      end
      S_ITER: begin
        if (cnt_r == '0) begin
          state_nxt = S_STORE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_STORE: begin
        if (chan_r) begin
          state_nxt = S_IDLE;
        end else begin
          chan_nxt  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/gwwb_datapath.sv
// -----------------------------------------------------------------------------
// Gray-world white balance datapath
// Channel sums, shared restoring divider for the gains, and the gain multiply.
// -----------------------------------------------------------------------------
module gwwb_datapath #(
  parameter int LOG_MAX_PIXELS = gwwb_pkg::LOG_MAX_PIXELS_DEF,
  parameter int SAMPLE_BITS    = gwwb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gwwb_pkg::dp_cmd_t          cmd,
  input  logic [gwwb_pkg::FIELD_W-1:0] red_in,
  input  logic [gwwb_pkg::FIELD_W-1:0] green_in,
  input  logic [gwwb_pkg::FIELD_W-1:0] blue_in,
  output logic [gwwb_pkg::FIELD_W-1:0] red_out,
  output logic [gwwb_pkg::FIELD_W-1:0] green_out,
  output logic [gwwb_pkg::FIELD_W-1:0] blue_out,
  output logic                       clipped
);
  import gwwb_pkg::*;

  localparam int SUM_W  = LOG_MAX_PIXELS + SAMPLE_BITS;
  localparam int SUM_W1 = SUM_W + 1;
  localparam int REM_W  = SUM_W + GAIN_FRAC;
  localparam int DIV_W  = SUM_W + GAIN_W - 1;
  localparam int CMP_W  = SUM_W + GAIN_W - GAIN_FRAC;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int SCL_W  = PROD_W - GAIN_FRAC;

  logic [SAMPLE_BITS-1:0] r_s, g_s, b_s;
  assign r_s = red_in[SAMPLE_BITS-1:0];
  assign g_s = green_in[SAMPLE_BITS-1:0];
  assign b_s = blue_in[SAMPLE_BITS-1:0];

  // architectural state
  logic [SUM_W-1:0]  red_sum_r, green_sum_r, blue_sum_r;
  logic [SUM_W-1:0]  red_sum_nxt, green_sum_nxt, blue_sum_nxt;
  logic [GAIN_W-1:0] red_gain_r, blue_gain_r, red_gain_nxt, blue_gain_nxt;
  logic              gain_sat_r, gain_sat_nxt;

  // divider
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [GAIN_W-1:0] quo_r, quo_nxt;
  logic              chan_sat_r, chan_sat_nxt;

  logic [SUM_W1-1:0] red_add, green_add, blue_add;
  logic [SUM_W-1:0]  den_sel;
  logic [DIV_W-1:0]  rem_ext, diff;
  logic              ge;
  logic [GAIN_W-1:0] gain_new;

  assign red_add   = {1'b0, red_sum_r}   + SUM_W1'(r_s);
  assign green_add = {1'b0, green_sum_r} + SUM_W1'(g_s);
  assign blue_add  = {1'b0, blue_sum_r}  + SUM_W1'(b_s);

  assign den_sel  = cmd.chan ? blue_sum_r : red_sum_r;
  assign rem_ext  = DIV_W'(rem_r);
  assign ge       = (rem_ext >= div_r);
  assign diff     = rem_ext - div_r;
  assign gain_new = chan_sat_r ? GAIN_MAX : quo_r;

  always_comb begin
    red_sum_nxt   = red_sum_r;
    green_sum_nxt = green_sum_r;
    blue_sum_nxt  = blue_sum_r;
    red_gain_nxt  = red_gain_r;
    blue_gain_nxt = blue_gain_r;
    gain_sat_nxt  = gain_sat_r;
    if (cmd.acc) begin
      // sums saturate instead of wrapping
      red_sum_nxt   = red_add[SUM_W]   ? {SUM_W{1'b1}} : red_add[SUM_W-1:0];
      green_sum_nxt = green_add[SUM_W] ? {SUM_W{1'b1}} : green_add[SUM_W-1:0];
      blue_sum_nxt  = blue_add[SUM_W]  ? {SUM_W{1'b1}} : blue_add[SUM_W-1:0];
    end
    if (cmd.store) begin
      if (cmd.chan) begin
        blue_gain_nxt = gain_new;
        gain_sat_nxt  = gain_sat_r | chan_sat_r;
      end else begin
        red_gain_nxt  = gain_new;
        gain_sat_nxt  = chan_sat_r;
      end
    end
    if (cmd.clear) begin
      red_sum_nxt   = '0;
      green_sum_nxt = '0;
      blue_sum_nxt  = '0;
    end
  end

  always_comb begin
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    quo_nxt      = quo_r;
    chan_sat_nxt = chan_sat_r;
    if (cmd.load) begin
      // quotient fits 24 bits unless green >= den * 2^8; a zero den lands here too
      chan_sat_nxt = CMP_W'(green_sum_r) >= {den_sel, {(GAIN_W-GAIN_FRAC){1'b0}}};
      rem_nxt      = {green_sum_r, {GAIN_FRAC{1'b0}}};
      div_nxt      = DIV_W'(den_sel) << (GAIN_W - 1);
      quo_nxt      = '0;
    end else if (cmd.step) begin
      rem_nxt = ge ? diff[REM_W-1:0] : rem_r;
      div_nxt = div_r >> 1;
      quo_nxt = {quo_r[GAIN_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_sum_r   <= '0;
      green_sum_r <= '0;
      blue_sum_r  <= '0;
      red_gain_r  <= GAIN_ONE;
      blue_gain_r <= GAIN_ONE;
      gain_sat_r  <= 1'b0;
    end else begin
      red_sum_r   <= red_sum_nxt;
      green_sum_r <= green_sum_nxt;
      blue_sum_r  <= blue_sum_nxt;
      red_gain_r  <= red_gain_nxt;
      blue_gain_r <= blue_gain_nxt;
      gain_sat_r  <= gain_sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    quo_r      <= quo_nxt;
    chan_sat_r <= chan_sat_nxt;
  end

  // apply: sample * gain, drop 16 fraction bits, clamp
  logic [PROD_W-1:0]      red_prod, blue_prod;
  logic [SCL_W-1:0]       red_scl, blue_scl;
  logic                   red_clip, blue_clip;
  logic [SAMPLE_BITS-1:0] red_val, blue_val;
  logic [FIELD_W-1:0]     red_out_r, green_out_r, blue_out_r;
  logic                   clipped_r;

  assign red_prod  = PROD_W'(r_s) * PROD_W'(red_gain_r);
  assign blue_prod = PROD_W'(b_s) * PROD_W'(blue_gain_r);
  assign red_scl   = red_prod[PROD_W-1:GAIN_FRAC];
  assign blue_scl  = blue_prod[PROD_W-1:GAIN_FRAC];
  assign red_clip  = |red_scl[SCL_W-1:SAMPLE_BITS];
  assign blue_clip = |blue_scl[SCL_W-1:SAMPLE_BITS];
  assign red_val   = red_clip  ? {SAMPLE_BITS{1'b1}} : red_scl[SAMPLE_BITS-1:0];
  assign blue_val  = blue_clip ? {SAMPLE_BITS{1'b1}} : blue_scl[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      red_out_r   <= FIELD_W'(red_val);
      green_out_r <= FIELD_W'(g_s);
      blue_out_r  <= FIELD_W'(blue_val);
      clipped_r   <= gain_sat_r | red_clip | blue_clip;
    end
  end

  assign red_out   = red_out_r;
  assign green_out = green_out_r;
  assign blue_out  = blue_out_r;
  assign clipped   = clipped_r;

endmodule

// File: rtl/gray_world_white_balance.sv
// -----------------------------------------------------------------------------
// Gray-world white balance, top level
// Accumulates channel sums over a statistics pass, derives red and blue gains
// as green/red and green/blue ratios, then scales pixels in an apply pass.
//
// Usage:
//   Input beats carry the op in in_tuser: statistics (0), finish (1),
//   apply (2); op 3 is taken and dropped. Samples ride in in_tdata.
//   Only apply beats produce an output beat; it appears on out_* the cycle
//   after acceptance and is held there until out_tready.
//   Statistics and apply pixels stream at one per cycle while no finish runs and
//   out_tready does not stall. A finish beat occupies the shared restoring
//   divider, red then blue, one quotient bit per cycle between load and store;
//   in_tready stays low meanwhile and the sums are zeroed at the end.
//   A stalled output register takes a new beat only when it drains that
//   same cycle, so a stall on out_tready backs up to in_tready.
//   Reset clears the sums and the gain flag and sets both gains to 1.0.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module gray_world_white_balance #(
  parameter int LOG_MAX_PIXELS = gwwb_pkg::LOG_MAX_PIXELS_DEF,
  parameter int SAMPLE_BITS    = gwwb_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input beat
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [3*gwwb_pkg::FIELD_W-1:0]  in_tdata,   // red_in, green_in, blue_in
  input  logic [gwwb_pkg::OP_W-1:0]       in_tuser,   // op
  // result beat
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [3*gwwb_pkg::FIELD_W-1:0]  out_tdata,  // red_out, green_out, blue_out
  output logic                            out_tuser   // clipped
);
  import gwwb_pkg::*;

  dp_cmd_t cmd;

  gwwb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gwwb_datapath #(
    .LOG_MAX_PIXELS (LOG_MAX_PIXELS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .red_in    (in_tdata[FIELD_W-1:0]),
    .green_in  (in_tdata[2*FIELD_W-1:FIELD_W]),
    .blue_in   (in_tdata[3*FIELD_W-1:2*FIELD_W]),
    .red_out   (out_tdata[FIELD_W-1:0]),
    .green_out (out_tdata[2*FIELD_W-1:FIELD_W]),
    .blue_out  (out_tdata[3*FIELD_W-1:2*FIELD_W]),
    .clipped   (out_tuser)
  );

  // no input taken while the divider runs
  `ASSERT_IMPLIES(a_busy_no_ready, clk, rst_n, cmd.load || cmd.step || cmd.store, !in_tready)
  // divider phases are exclusive
  `ASSERT_ALWAYS(a_div_onehot, clk, rst_n, $onehot0({cmd.load, cmd.step, cmd.store}))
  // an accepted apply beat always yields a result next cycle
  `ASSERT_NEXT(a_apply_result, clk, rst_n, in_tvalid && in_tready && (in_tuser == OP_APPLY), out_tvalid)

endmodule

// File: sim/gray_world_white_balance_test.sv
// -----------------------------------------------------------------------------
// Gray-world white balance testbench
// Streams statistics, finish and apply beats through the block under random
// stalls on both sides and checks every result beat against a cycle-free
// model of the sums, the 8.16 gains and the clip flag.
// -----------------------------------------------------------------------------
module gray_world_white_balance_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gwwb_pkg::*;

  // sums are LOG_MAX_PIXELS + SAMPLE_BITS wide and saturate there
  localparam int SUM_W = LOG_MAX_PIXELS_DEF + SAMPLE_BITS_DEF;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [FIELD_W-1:0] SAMPLE_MAX = {FIELD_W{1'b1}};
  // op 3 has no enum member; the block drops it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 9;
  localparam int RANDOM_BEATS = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 150;   // apply beats taken before the long stall
  localparam int DRAIN_CYCLES = 60;    // lets a trailing finish run through the divider

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
  } pixel_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] red;
    logic [FIELD_W-1:0] green;
    logic [FIELD_W-1:0] blue;
    logic               clipped;
  } balanced_px_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [3*FIELD_W-1:0]   in_tdata = '0;   // red_in, green_in, blue_in
  logic [OP_W-1:0]        in_tuser = '0;   // op
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [3*FIELD_W-1:0]   out_tdata;       // red_out, green_out, blue_out
  logic                   out_tuser;       // clipped

  pixel_beat_t  pending_beats[$];
  balanced_px_t balanced_q[$];

  // model state
  logic [SUM_W-1:0]  red_acc, green_acc, blue_acc;
  logic [GAIN_W-1:0] red_gain, blue_gain;
  logic              gains_clamped;

  int     fail_cnt = 0;
  int     cycle_cnt = 0;
  int     applies_taken = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  logic   in_fire = 1'b0;

  gray_world_white_balance i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic logic [SUM_W-1:0] sum_add(input logic [SUM_W-1:0] acc,
                                               input logic [FIELD_W-1:0] sample);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W+1)'(sample);
    if (s > (SUM_W+1)'(SUM_MAX)) return SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  // {saturated, gain}: green over channel in 8.16, zero divisor saturates
  function automatic logic [GAIN_W:0] gain_ratio(input logic [SUM_W-1:0] num,
                                                 input logic [SUM_W-1:0] den);
    logic [63:0] q;
    if (den == '0) return {1'b1, GAIN_MAX};
    q = (64'(num) << GAIN_FRAC) / 64'(den);
    if (q > 64'(GAIN_MAX)) return {1'b1, GAIN_MAX};
    return {1'b0, q[GAIN_W-1:0]};
  endfunction

  // {clipped, sample * gain >> 16}
  function automatic logic [FIELD_W:0] scale_sample(input logic [FIELD_W-1:0] sample,
                                                    input logic [GAIN_W-1:0] gain);
    logic [FIELD_W+GAIN_W-1:0] p;
    p = (FIELD_W+GAIN_W)'(sample) * (FIELD_W+GAIN_W)'(gain);
    p = p >> GAIN_FRAC;
    if (p > (FIELD_W+GAIN_W)'(SAMPLE_MAX)) return {1'b1, SAMPLE_MAX};
    return {1'b0, p[FIELD_W-1:0]};
  endfunction

  task automatic predict_balance(input pixel_beat_t px);
    logic [GAIN_W:0]  rg, bg;
    logic [FIELD_W:0] rs, bs;
    balanced_px_t     res;
    case (px.op)
      OP_STAT: begin
        red_acc   = sum_add(red_acc, px.red);
        green_acc = sum_add(green_acc, px.green);
        blue_acc  = sum_add(blue_acc, px.blue);
      end
      OP_FINISH: begin
        rg = gain_ratio(green_acc, red_acc);
        bg = gain_ratio(green_acc, blue_acc);
        red_gain      = rg[GAIN_W-1:0];
        blue_gain     = bg[GAIN_W-1:0];
        gains_clamped = rg[GAIN_W] | bg[GAIN_W];
        red_acc   = '0;
        green_acc = '0;
        blue_acc  = '0;
      end
      OP_APPLY: begin
        rs = scale_sample(px.red, red_gain);
        bs = scale_sample(px.blue, blue_gain);
        res.red     = rs[FIELD_W-1:0];
        res.green   = px.green;
        res.blue    = bs[FIELD_W-1:0];
        res.clipped = gains_clamped | rs[FIELD_W] | bs[FIELD_W];
        balanced_q  = {balanced_q, res};
      end
      default: ;  // unused op: dropped, no state change
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] r,
                            input logic [FIELD_W-1:0] g, input logic [FIELD_W-1:0] b);
    pixel_beat_t px;
    px.op    = op;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pending_beats = {pending_beats, px};
  endtask

  // per-channel span for a frame; small spans drive gains toward saturation
  function automatic int unsigned sample_span();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 255;
      3:       return 4095;
      default: return 65535;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: a new beat goes out at the falling edge once the last one is taken
  // ---------------------------------------------------------------------------
  wire calm = (cycle_cnt >= 300) && (cycle_cnt < 1100);  // no idling here

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (pending_beats.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_beats[0].op;
        in_tdata  <= {pending_beats[0].blue, pending_beats[0].green, pending_beats[0].red};
        pending_beats.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off once applies are flowing,
  // so the output register fills and in_tready drops
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && applies_taken >= HOLD_AFTER) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: results are checked first, then the accepted input is predicted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    balanced_px_t want;
    pixel_beat_t  taken;
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (balanced_q.size() == 0) begin
          $error("result beat with no pending expectation: %h/%b", out_tdata, out_tuser);
          fail_cnt++;
        end else begin
          want = balanced_q.pop_front();
          if (out_tdata[FIELD_W-1:0] !== want.red) begin
            $error("red_out: expected %h, got %h", want.red, out_tdata[FIELD_W-1:0]);
            fail_cnt++;
          end
          if (out_tdata[2*FIELD_W-1:FIELD_W] !== want.green) begin
            $error("green_out: expected %h, got %h", want.green,
                   out_tdata[2*FIELD_W-1:FIELD_W]);
            fail_cnt++;
          end
          if (out_tdata[3*FIELD_W-1:2*FIELD_W] !== want.blue) begin
            $error("blue_out: expected %h, got %h", want.blue,
                   out_tdata[3*FIELD_W-1:2*FIELD_W]);
            fail_cnt++;
          end
          if (out_tuser !== want.clipped) begin
            $error("clipped: expected %b, got %b", want.clipped, out_tuser);
            fail_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        taken.op    = in_tuser;
        taken.red   = in_tdata[FIELD_W-1:0];
        taken.green = in_tdata[2*FIELD_W-1:FIELD_W];
        taken.blue  = in_tdata[3*FIELD_W-1:2*FIELD_W];
        if (taken.op == OP_APPLY) applies_taken <= applies_taken + 1;
        predict_balance(taken);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int counted;
    int n;
    int unsigned rspan, gspan, bspan;
    red_acc       = '0;
    green_acc     = '0;
    blue_acc      = '0;
    red_gain      = GAIN_ONE;
    blue_gain     = GAIN_ONE;
    gains_clamped = 1'b0;

    // directed: reset gains are unity
    queue_beat(OP_APPLY, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(OP_APPLY, 16'hA5A5, 16'h5A5A, 16'h1234);
    queue_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // finish over empty sums: both divisors zero, green zero too
    queue_beat(OP_FINISH, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(OP_APPLY, 16'h0001, 16'h8000, 16'h0001);
    // balanced frame clears the flag again
    queue_beat(OP_STAT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(OP_STAT, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_FINISH, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'hFFFF, 16'h0000, 16'hFFFF);
    // red ratio too large, blue sum zero
    queue_beat(OP_STAT, 16'h0001, 16'hFFFF, 16'h0000);
    queue_beat(OP_FINISH, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'h0010, 16'h0020, 16'h0030);
    // red gain near 2.0: output clipping without a clamped gain
    queue_beat(OP_STAT, 16'h8000, 16'hFFFF, 16'hFFFF);
    queue_beat(OP_FINISH, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'hFFFF, 16'h0001, 16'h7FFF);
    queue_beat(OP_APPLY, 16'h7FFF, 16'h0000, 16'h0000);
    // gains below one
    queue_beat(OP_STAT, 16'h0100, 16'h0001, 16'hFFFF);
    queue_beat(OP_STAT, 16'h0200, 16'h0001, 16'hFFFF);
    queue_beat(OP_FINISH, 16'h0000, 16'h0000, 16'h0000);
    queue_beat(OP_APPLY, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_beat(OP_UNUSED, 16'h0000, 16'h0000, 16'h0000);

    // random frames: statistics pass, finish, apply pass, with some noise
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      rspan = sample_span();
      gspan = sample_span();
      bspan = sample_span();
      if ($urandom_range(0, 9) == 0) begin
        // broken sequence: applies or a finish with no statistics first
        queue_beat($urandom_range(0, 1) ? OP_APPLY : OP_FINISH, 16'($urandom),
                   16'($urandom), 16'($urandom));
        counted++;
      end
      n = $urandom_range(1, 30);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          queue_beat(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        queue_beat(OP_STAT, 16'($urandom_range(0, rspan)), 16'($urandom_range(0, gspan)),
                   16'($urandom_range(0, bspan)));
      end
      queue_beat(OP_FINISH, 16'($urandom), 16'($urandom), 16'($urandom));
      counted += n + 1;
      n = $urandom_range(1, 30);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          queue_beat(OP_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
        queue_beat(OP_APPLY, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      counted += n;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_beats.size() != 0 || in_tvalid) @(posedge clk);
    while (balanced_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (balanced_q.size() != 0) begin
      $error("%0d expected results never arrived", balanced_q.size());
      fail_cnt++;
    end

    if (fail_cnt == 0) begin
      $display("gray_world_white_balance test passed");
    end else begin
      $display("gray_world_white_balance test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("gray_world_white_balance test failed");
    $finish;
  end

endmodule

// File: gray_world_white_balance.f
+incdir+rtl
rtl/gwwb_pkg.sv
rtl/gwwb_ctrl.sv
rtl/gwwb_datapath.sv
rtl/gray_world_white_balance.sv
sim/gray_world_white_balance_test.sv
